// ===== hw/rtl/kit_mapping_text_parser_unit_macros.svh =====
// Assertion macros used by the result queue of the kit mapping text parser.
`ifndef KIT_MAPPING_TEXT_PARSER_UNIT_MACROS_SVH
`define KIT_MAPPING_TEXT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication.
`define KMTP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmtp: same-cycle check failed");

// Next-cycle implication.
`define KMTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmtp: next-cycle check failed");

`endif

// ===== hw/rtl/kmtp_pkg.sv =====
// Shared types and constants of the kit mapping text parser.
package kmtp_pkg;

   localparam int PAD_COUNT = 11;
   localparam logic [3:0] PAD_NONE = 4'd15;
   localparam int Q_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_RESTART   = 2'd0,
      CMD_FEED      = 2'd1,
      CMD_READ_NAME = 2'd2,
      CMD_READ_FILE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      LS_NEWLINE = 3'd0,
      LS_COMMENT = 3'd1,
      LS_KITNAME = 3'd2,
      LS_MAPPING = 3'd3,
      LS_INVALID = 3'd4
   } line_state_type;

   typedef struct packed {
      logic [7:0]     read_char;
      line_state_type parse_state;
      logic           kit_found;
      logic [7:0]     kits_seen;
   } rsp_entry_type;

   typedef struct packed {
      logic          valid;
      rsp_entry_type entry;
   } q_push_type;

endpackage

// ===== hw/rtl/kmtp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/kmtp_front.sv =====
// Front end: line parser, name and filename stores, read issue stage.
module kmtp_front
   import kmtp_pkg::*;
#(
   parameter int KIT_NAME_LEN  = 16,
   parameter int FILE_NAME_LEN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   input  logic       in_fire,
   input  cmd_type    cmd,
   input  logic [7:0] byte_value,
   input  logic [3:0] pad_select,
   input  logic [3:0] char_pos,
   output q_push_type q_push
);

   localparam int LW     = $clog2(KIT_NAME_LEN + 1);
   localparam int NAW    = $clog2(KIT_NAME_LEN);
   localparam int FLW    = $clog2(FILE_NAME_LEN + 1);
   localparam int FDEPTH = PAD_COUNT * FILE_NAME_LEN;
   localparam int FAW    = $clog2(FDEPTH);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] NOT_SET  = 8'hFF;

   localparam logic [7:0] KEY_FIRST [PAD_COUNT] =
      '{"H", "S", "B", "T", "C", "T", "T", "S", "R", "X", "X"};
   localparam logic [7:0] KEY_SECOND [PAD_COUNT] =
      '{"H", "N", "S", "1", "R", "2", "3", "P", "D", "0", "1"};

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic [3:0] pad_lookup(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] hit;
      hit = PAD_NONE;
      for (int k = PAD_COUNT - 1; k >= 0; k--) begin
         if (a == KEY_FIRST[k] && b == KEY_SECOND[k]) begin
            hit = 4'(k);
         end
      end
      return hit;
   endfunction

   // parser state
   logic [6:0]     kit_select_ff;
   line_state_type line_state_ff, line_state_in;
   logic [7:0]     kit_counter_ff, kit_counter_in;
   logic [LW-1:0]  name_length_ff, name_length_in;
   logic [7:0]     field_position_ff, field_position_in;
   logic [7:0]     first_key_ff, first_key_in;
   logic [3:0]     current_pad_ff, current_pad_in;
   logic [FLW-1:0] file_len_ff [PAD_COUNT];

   // store writes
   logic           name_we;
   logic [NAW-1:0] name_waddr;
   logic           file_we;
   logic [FAW-1:0] file_waddr;
   logic           len_we;
   logic [3:0]     len_pad;
   logic [FLW-1:0] len_val;

   // read issue
   logic [NAW-1:0] name_raddr;
   logic [FAW-1:0] file_raddr;
   logic [3:0]     pad_idx;
   logic           rd_ok;
   logic [7:0]     name_rdata;
   logic [7:0]     file_rdata;

   // stage two
   logic           s2_valid_ff;
   logic           s2_is_name_ff;
   logic           s2_rd_ok_ff;
   line_state_type s2_state_ff;
   logic [7:0]     s2_kits_ff;
   logic           s2_found_ff;

   logic       feed;
   logic       is_sel_kit;
   logic       kit_match;
   logic       map_char_ok;
   logic [7:0] file_idx;
   logic [3:0] key_pad;

   assign feed        = in_fire && cmd == CMD_FEED;
   assign is_sel_kit  = kit_counter_ff != 8'd0 && kit_counter_ff != 8'd255 &&
                        (kit_counter_ff - 8'd1) == {1'b0, kit_select_ff};
   assign kit_match   = kit_counter_ff != 8'd255 && kit_counter_ff == {1'b0, kit_select_ff};
   assign map_char_ok = is_alnum(byte_value) || byte_value == CH_DOT ||
                        byte_value == CH_COMMA || byte_value == CH_COLON;
   assign file_idx    = field_position_ff - 8'd3;
   assign key_pad     = pad_lookup(first_key_ff, byte_value);

   // next state
   always_comb begin
      line_state_in     = line_state_ff;
      kit_counter_in    = kit_counter_ff;
      name_length_in    = name_length_ff;
      field_position_in = field_position_ff;
      first_key_in      = first_key_ff;
      current_pad_in    = current_pad_ff;
      if (in_fire) begin
         unique case (cmd)
            CMD_RESTART: begin
               line_state_in     = LS_NEWLINE;
               kit_counter_in    = 8'd0;
               field_position_in = 8'd0;
               first_key_in      = NOT_SET;
               current_pad_in    = PAD_NONE;
            end
            CMD_FEED: begin
               unique case (line_state_ff) inside
                  LS_INVALID, LS_COMMENT: begin
                     if (is_eol(byte_value)) begin
                        line_state_in = LS_NEWLINE;
                     end
                  end
                  LS_NEWLINE: begin
                     if (is_alnum(byte_value)) begin
                        if (kit_counter_ff != 8'd255) begin
                           kit_counter_in = kit_counter_ff + 8'd1;
                        end
                        if (kit_match) begin
                           name_length_in = LW'(1);
                           line_state_in  = LS_KITNAME;
                        end else begin
                           line_state_in = LS_COMMENT;
                        end
                     end else if (byte_value == CH_TAB) begin
                        if (is_sel_kit) begin
                           line_state_in     = LS_MAPPING;
                           field_position_in = 8'd0;
                           first_key_in      = NOT_SET;
                           current_pad_in    = PAD_NONE;
                        end else begin
                           line_state_in = LS_COMMENT;
                        end
                     end else if (byte_value == CH_HASH) begin
                        line_state_in = LS_COMMENT;
                     end else if (!is_eol(byte_value)) begin
                        line_state_in = LS_INVALID;
                     end
                  end
                  LS_KITNAME: begin
                     if (is_alnum(byte_value)) begin
                        if (name_length_ff < LW'(KIT_NAME_LEN)) begin
                           name_length_in = name_length_ff + LW'(1);
                        end
                     end else if (is_eol(byte_value)) begin
                        line_state_in = LS_NEWLINE;
                     end else begin
                        line_state_in = LS_INVALID;
                     end
                  end
                  LS_MAPPING: begin
                     if (is_eol(byte_value)) begin
                        line_state_in = LS_NEWLINE;
                     end else begin
                        if (!map_char_ok) begin
                           line_state_in = LS_INVALID;
                        end else if (field_position_ff == 8'd0) begin
                           first_key_in = byte_value;
                        end else if (field_position_ff == 8'd1) begin
                           current_pad_in = key_pad;
                           if (key_pad == PAD_NONE) begin
                              line_state_in = LS_INVALID;
                           end
                        end else if (field_position_ff == 8'd2) begin
                           if (!(byte_value == CH_COLON && current_pad_ff < 4'(PAD_COUNT))) begin
                              line_state_in = LS_INVALID;
                           end
                        end else if (byte_value == CH_COLON) begin
                           line_state_in = LS_INVALID;
                        end
                        if (field_position_ff != 8'd255) begin
                           field_position_in = field_position_ff + 8'd1;
                        end
                     end
                  end
                  default: begin
                     line_state_in = LS_INVALID;
                  end
               endcase
            end
            CMD_READ_NAME, CMD_READ_FILE: begin
            end
         endcase
      end
   end

   // store writes
   always_comb begin
      name_we    = 1'b0;
      name_waddr = NAW'(name_length_ff);
      file_we    = 1'b0;
      file_waddr = FAW'(int'(current_pad_ff) * FILE_NAME_LEN + int'(file_idx));
      len_we     = 1'b0;
      len_pad    = current_pad_ff;
      len_val    = '0;
      if (feed) begin
         unique case (line_state_ff) inside
            LS_NEWLINE: begin
               if (is_alnum(byte_value) && kit_match) begin
                  name_we    = 1'b1;
                  name_waddr = '0;
               end
            end
            LS_KITNAME: begin
               if (is_alnum(byte_value) && name_length_ff < LW'(KIT_NAME_LEN)) begin
                  name_we = 1'b1;
               end
            end
            LS_MAPPING: begin
               if (!is_eol(byte_value) && map_char_ok &&
                   current_pad_ff < 4'(PAD_COUNT)) begin
                  if (field_position_ff == 8'd2 && byte_value == CH_COLON) begin
                     len_we = 1'b1;
                  end else if (field_position_ff > 8'd2 && byte_value != CH_COLON &&
                               file_idx < 8'(FILE_NAME_LEN)) begin
                     file_we = 1'b1;
                     len_we  = 1'b1;
                     len_val = FLW'(file_idx) + FLW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // read issue
   always_comb begin
      pad_idx    = (pad_select < 4'(PAD_COUNT)) ? pad_select : 4'd0;
      name_raddr = NAW'(char_pos);
      file_raddr = FAW'(int'(pad_idx) * FILE_NAME_LEN + int'(char_pos));
      if (cmd == CMD_READ_NAME) begin
         rd_ok = 8'(char_pos) < 8'(name_length_ff) && 8'(char_pos) < 8'(KIT_NAME_LEN);
      end else begin
         rd_ok = pad_select < 4'(PAD_COUNT) &&
                 8'(char_pos) < 8'(file_len_ff[pad_idx]) &&
                 8'(char_pos) < 8'(FILE_NAME_LEN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kit_select_ff     <= '0;
         line_state_ff     <= LS_NEWLINE;
         kit_counter_ff    <= '0;
         name_length_ff    <= '0;
         field_position_ff <= '0;
         first_key_ff      <= NOT_SET;
         current_pad_ff    <= PAD_NONE;
         s2_valid_ff       <= 1'b0;
         for (int p = 0; p < PAD_COUNT; p++) begin
            file_len_ff[p] <= '0;
         end
      end else begin
         if (csr_we) begin
            kit_select_ff <= csr_wdata;
         end
         line_state_ff     <= line_state_in;
         kit_counter_ff    <= kit_counter_in;
         name_length_ff    <= name_length_in;
         field_position_ff <= field_position_in;
         first_key_ff      <= first_key_in;
         current_pad_ff    <= current_pad_in;
         s2_valid_ff       <= in_fire;
         if (len_we) begin
            file_len_ff[len_pad] <= len_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         s2_is_name_ff <= cmd == CMD_READ_NAME;
         s2_rd_ok_ff   <= (cmd == CMD_READ_NAME || cmd == CMD_READ_FILE) && rd_ok;
         s2_state_ff   <= line_state_in;
         s2_kits_ff    <= kit_counter_in;
         s2_found_ff   <= kit_counter_in > {1'b0, kit_select_ff};
      end
   end

   kmtp_ram #(
      .WIDTH (8),
      .DEPTH (KIT_NAME_LEN)
   ) u_name_ram (
      .clock (clock),
      .we    (name_we),
      .waddr (name_waddr),
      .wdata (byte_value),
      .raddr (name_raddr),
      .rdata (name_rdata)
   );

   kmtp_ram #(
      .WIDTH (8),
      .DEPTH (FDEPTH)
   ) u_file_ram (
      .clock (clock),
      .we    (file_we),
      .waddr (file_waddr),
      .wdata (byte_value),
      .raddr (file_raddr),
      .rdata (file_rdata)
   );

   always_comb begin
      q_push.valid             = s2_valid_ff;
      q_push.entry.read_char   = s2_rd_ok_ff ? (s2_is_name_ff ? name_rdata : file_rdata) : 8'd0;
      q_push.entry.parse_state = s2_state_ff;
      q_push.entry.kit_found   = s2_found_ff;
      q_push.entry.kits_seen   = s2_kits_ff;
   end

endmodule

// ===== hw/rtl/kmtp_queue.sv =====
// Result queue between the front end and the result port, credit based.
`include "kit_mapping_text_parser_unit_macros.svh"

module kmtp_queue
   import kmtp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  q_push_type    push,
   input  logic          pop,
   output logic          empty,
   output logic          full,
   output rsp_entry_type head
);

   localparam int PW = $clog2(Q_DEPTH);
   localparam int CW = $clog2(Q_DEPTH + 1);

   rsp_entry_type  slot_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop_fire;

   assign empty    = count_ff == '0;
   assign pop_fire = pop && !empty;
   // the word in the front's second stage already holds a slot
   assign full     = (CW'(count_ff) + CW'(push.valid)) >= CW'(Q_DEPTH);
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.valid) - CW'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   `KMTP_ASSERT_NOW(a_no_overflow, clock, reset, push.valid, count_ff < CW'(Q_DEPTH))
   `KMTP_ASSERT_NEXT(a_grow, clock, reset, push.valid && !pop_fire, count_ff == $past(count_ff) + CW'(1))
   `KMTP_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty)

endmodule

// ===== hw/rtl/kit_mapping_text_parser_unit.sv =====
// Top level of the kit mapping text parser.
// Usage notes:
//  - Request side is a queue write port: a word is taken when req_push is high
//    and req_full is low. req_command selects restart, feed one text byte,
//    read a kit name character or read a pad filename character.
//  - Response side is a queue read port: while rsp_empty is low the oldest
//    response sits on the rsp_ ports; rsp_pop takes it.
//  - Exactly one response word per request word, in request order.
//  - Path: a request is parsed and its store read issued into stage two; the
//    store read data then forms the result, which is written into the response
//    queue and shows on the rsp_ ports once it is the oldest entry.
//  - Throughput: one request per cycle while responses are popped; the four
//    entry response queue counts the word in flight, so req_full rises only
//    when the consumer stalls and the queue plus stage two would fill.
//  - csr_we/csr_wdata write kit_select; write it only while the block is idle.
//  - Synchronous active-high reset clears parser state, filename lengths, the
//    kit name length and the queue; the name and filename stores keep their
//    contents, which are never visible past a stored length.
module kit_mapping_text_parser_unit
   import kmtp_pkg::*;
#(
   parameter int KIT_NAME_LEN  = 16,
   parameter int FILE_NAME_LEN = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_command,
   input  logic [7:0] req_byte_value,
   input  logic [3:0] req_pad_select,
   input  logic [3:0] req_char_pos,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_read_char,
   output logic [2:0] rsp_parse_state,
   output logic       rsp_kit_found,
   output logic [7:0] rsp_kits_seen
);

   q_push_type    q_push;
   rsp_entry_type head;
   logic          in_fire;

   assign in_fire = req_push && !req_full;

   // front: parser and stores
   kmtp_front #(
      .KIT_NAME_LEN  (KIT_NAME_LEN),
      .FILE_NAME_LEN (FILE_NAME_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_fire    (in_fire),
      .cmd        (cmd_type'(req_command)),
      .byte_value (req_byte_value),
      .pad_select (req_pad_select),
      .char_pos   (req_char_pos),
      .q_push     (q_push)
   );

   // back: response queue
   kmtp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .full  (req_full),
      .head  (head)
   );

   assign rsp_read_char   = head.read_char;
   assign rsp_parse_state = 3'(head.parse_state);
   assign rsp_kit_found   = head.kit_found;
   assign rsp_kits_seen   = head.kits_seen;

endmodule
